@@ hdl/cubic_spline_segment_sampler_macros.svh @@
// assertion macros for the cubic spline segment sampler
// expects clk and rst_n in the scope of the module that uses them
`ifndef CUBIC_SPLINE_SEGMENT_SAMPLER_MACROS_SVH
`define CUBIC_SPLINE_SEGMENT_SAMPLER_MACROS_SVH
`ifndef SYNTHESIS
`define CSS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cubic spline sampler: same-cycle check failed");
`define CSS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cubic spline sampler: next-cycle check failed");
`else
`define CSS_ASSERT_SAME(lbl, ante, cons)
`define CSS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hdl/cssp_pkg.sv @@
// shared constants, state and command types of the cubic spline segment sampler
// no dependencies
package cssp_pkg;

    localparam int X_W       = 11;
    localparam int Y_W       = 15;
    localparam int STEP_W    = 11;
    localparam int MAX_SEGMENT_SAMPLES = 64;
    localparam int CNT_W     = $clog2(MAX_SEGMENT_SAMPLES + 1);
    localparam int M_W       = 27;
    localparam int Y_MAX     = 32767;
    localparam int DIV_W     = 64;
    localparam int Q_W       = 36;
    localparam int ITER_W    = 6;
    localparam int CHORD_ITERS = 36;
    localparam int SMP_ITERS = 15;
    localparam int STEP_RESET = 32;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;
    localparam logic [0:0] REG_SAMPLE_STEP = 1'b0;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_PREP,
        ST_BOTHDUP,
        ST_CH_MUL,
        ST_CH_START,
        ST_CH_WAIT,
        ST_CH_FIN,
        ST_END,
        ST_COEF,
        ST_COEF2,
        ST_COEF3,
        ST_SMP1,
        ST_SMP2,
        ST_SMP3,
        ST_SMP4,
        ST_DIV_WAIT,
        ST_DIV_FIN,
        ST_OUT
    } ctl_state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_APPEND,
        OP_SHIFT,
        OP_PREP,
        OP_BOTHDUP,
        OP_CH_MUL,
        OP_CH_START,
        OP_CH_FIN,
        OP_END,
        OP_COEF,
        OP_COEF2,
        OP_COEF3,
        OP_SMP1,
        OP_SMP2,
        OP_SMP3,
        OP_SMP4,
        OP_DIV_FIN,
        OP_ADVANCE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   sel;
    } dp_cmd_t;

    typedef struct packed {
        logic held_full;
        logic seg_fwd;
        logic dup0;
        logic dup3;
        logic div_busy;
        logic last_smp;
        logic y_neg;
        logic y_sat;
    } dp_status_t;

endpackage

@@ hdl/cssp_if.sv @@
// request channel interfaces: control points in, curve samples out
// depends on cssp_pkg
interface cssp_point_if;
    import cssp_pkg::*;
    logic             valid;
    logic             ready;
    logic [X_W-1:0]   point_x;
    logic [Y_W-1:0]   point_y;
    logic             first_of_curve;
    modport source (output valid, point_x, point_y, first_of_curve, input ready);
    modport sink (input valid, point_x, point_y, first_of_curve, output ready);
endinterface

interface cssp_sample_if;
    import cssp_pkg::*;
    logic             valid;
    logic             ready;
    logic [X_W-1:0]   sample_x;
    logic [Y_W-1:0]   sample_y;
    logic             last_of_segment;
    modport source (output valid, sample_x, sample_y, last_of_segment, input ready);
    modport sink (input valid, sample_x, sample_y, last_of_segment, output ready);
endinterface

@@ hdl/cssp_div.sv @@
// restoring unsigned divider, one quotient bit per cycle
// depends on cssp_pkg; divisor arrives pre-shifted to the top quotient bit
module cssp_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [cssp_pkg::DIV_W-1:0]  dividend,
    input  logic [cssp_pkg::DIV_W-1:0]  divisor,
    input  logic [cssp_pkg::ITER_W-1:0] iters,
    output logic                        busy,
    output logic [cssp_pkg::Q_W-1:0]    quot,
    output logic                        rem_nz
);
    import cssp_pkg::*;

    logic              busy_reg, busy_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  dsh_reg, dsh_next;
    logic [Q_W-1:0]    q_reg, q_next;
    logic              ge;

    assign ge = rem_reg >= dsh_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = iters;
            rem_next  = dividend;
            dsh_next  = divisor;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? rem_reg - dsh_reg : rem_reg;
            q_next   = {q_reg[Q_W-2:0], ge};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - ITER_W'(1);
            if (cnt_reg == ITER_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign busy   = busy_reg;
    assign quot   = q_reg;
    assign rem_nz = rem_reg != '0;

endmodule

@@ hdl/cssp_ctrl.sv @@
// sequencer: walks one control point through window update, tangent setup
// and the sample loop; depends on cssp_pkg
module cssp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  cssp_pkg::dp_status_t status,
    output cssp_pkg::dp_cmd_t    cmd
);
    import cssp_pkg::*;

    ctl_state_t state_reg, state_next;
    logic       sel_reg, sel_next;

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                if (!status.held_full || !status.seg_fwd)
                    state_next = ST_IDLE;
                else
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                if (status.dup0 && status.dup3)
                    state_next = ST_BOTHDUP;
                else
                begin
                    state_next = ST_CH_MUL;
                    sel_next   = status.dup0;
                end
            end
            ST_BOTHDUP:  state_next = ST_COEF;
            ST_CH_MUL:   state_next = ST_CH_START;
            ST_CH_START: state_next = ST_CH_WAIT;
            ST_CH_WAIT:  if (!status.div_busy) state_next = ST_CH_FIN;
            ST_CH_FIN:
            begin
                if (!sel_reg)
                begin
                    if (status.dup3)
                        state_next = ST_END;
                    else
                    begin
                        state_next = ST_CH_MUL;
                        sel_next   = 1'b1;
                    end
                end
                else if (status.dup0)
                    state_next = ST_END;
                else
                    state_next = ST_COEF;
            end
            ST_END:      state_next = ST_COEF;
            ST_COEF:     state_next = ST_COEF2;
            ST_COEF2:    state_next = ST_COEF3;
            ST_COEF3:    state_next = ST_SMP1;
            ST_SMP1:     state_next = ST_SMP2;
            ST_SMP2:     state_next = ST_SMP3;
            ST_SMP3:     state_next = ST_SMP4;
            ST_SMP4:
            begin
                if (status.y_neg || status.y_sat)
                    state_next = ST_OUT;
                else
                    state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: if (!status.div_busy) state_next = ST_DIV_FIN;
            ST_DIV_FIN:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_ready)
                    state_next = status.last_smp ? ST_IDLE : ST_SMP1;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cmd.sel   = sel_reg;
        cmd.op    = OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) cmd.op = OP_LOAD;
            end
            ST_DECIDE:
            begin
                if (!status.held_full)
                    cmd.op = OP_APPEND;
                else if (!status.seg_fwd)
                    cmd.op = OP_SHIFT;
                else
                    cmd.op = OP_PREP;
            end
            ST_PREP:     cmd.op = OP_NONE;
            ST_BOTHDUP:  cmd.op = OP_BOTHDUP;
            ST_CH_MUL:   cmd.op = OP_CH_MUL;
            ST_CH_START: cmd.op = OP_CH_START;
            ST_CH_WAIT:  cmd.op = OP_NONE;
            ST_CH_FIN:   cmd.op = OP_CH_FIN;
            ST_END:      cmd.op = OP_END;
            ST_COEF:     cmd.op = OP_COEF;
            ST_COEF2:    cmd.op = OP_COEF2;
            ST_COEF3:    cmd.op = OP_COEF3;
            ST_SMP1:     cmd.op = OP_SMP1;
            ST_SMP2:     cmd.op = OP_SMP2;
            ST_SMP3:     cmd.op = OP_SMP3;
            ST_SMP4:     cmd.op = OP_SMP4;
            ST_DIV_WAIT: cmd.op = OP_NONE;
            ST_DIV_FIN:  cmd.op = OP_DIV_FIN;
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready) cmd.op = OP_ADVANCE;
            end
            default:     cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

endmodule

@@ hdl/cssp_datapath.sv @@
// point window, tangent and coefficient registers, sample evaluator
// depends on cssp_pkg and cssp_div
module cssp_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cssp_pkg::dp_cmd_t            cmd,
    output cssp_pkg::dp_status_t         status,
    input  logic [cssp_pkg::X_W-1:0]     in_x,
    input  logic [cssp_pkg::Y_W-1:0]     in_y,
    input  logic                         in_first,
    input  logic [cssp_pkg::STEP_W-1:0]  step,
    output logic [cssp_pkg::X_W-1:0]     smp_x,
    output logic [cssp_pkg::Y_W-1:0]     smp_y,
    output logic                         smp_last
);
    import cssp_pkg::*;

    localparam logic signed [39:0] TAN_HI = 40'sd33554432;
    localparam logic signed [39:0] TAN_LO = -40'sd33554432;

    function automatic logic signed [M_W-1:0] sat_tan(input logic signed [39:0] v);
        logic signed [39:0] r;
        begin
            r = v;
            if (v > TAN_HI)
                r = TAN_HI;
            else if (v < TAN_LO)
                r = TAN_LO;
            sat_tan = r[M_W-1:0];
        end
    endfunction

    logic [1:0]           held_reg;
    logic [X_W-1:0]       win_x_reg [3];
    logic [Y_W-1:0]       win_y_reg [3];
    logic [X_W-1:0]       nx_reg;
    logic [Y_W-1:0]       ny_reg;
    logic [X_W-1:0]       dx_reg;
    logic signed [15:0]   dy_reg;
    logic signed [28:0]   prod_reg;
    logic [11:0]          cden_reg;
    logic                 cneg_reg;
    logic                 czero_reg;
    logic                 dneg_reg;
    logic signed [M_W-1:0] m1_reg, m2_reg;
    logic signed [28:0]   cc_reg, ec_reg;
    logic [21:0]          dsq_reg;
    logic signed [41:0]   ccdx_reg;
    logic signed [49:0]   m1dx2_reg;
    logic [32:0]          dcube_reg;
    logic [47:0]          y1den_reg;
    logic [X_W:0]         xcur_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic signed [42:0]   t1_reg;
    logic signed [56:0]   t2_reg;
    logic signed [63:0]   t3_reg;
    logic [X_W-1:0]       out_x_reg;
    logic [Y_W-1:0]       out_y_reg;
    logic                 out_last_reg;

    // divider hookup
    logic                 div_start;
    logic [DIV_W-1:0]     div_dividend, div_divisor;
    logic [ITER_W-1:0]    div_iters;
    logic                 div_busy;
    logic [Q_W-1:0]       div_q;
    logic                 div_rnz;

    // derived values
    logic [STEP_W-1:0]    step_eff;
    logic [X_W:0]         x_next;
    logic signed [12:0]   u_s;
    logic signed [12:0]   dx_s;
    logic [X_W-1:0]       xa, xb;
    logic [Y_W-1:0]       ya, yb;
    logic signed [15:0]   dyc;
    logic signed [11:0]   denc;
    logic signed [28:0]   prod_w;
    logic signed [39:0]   num40, nsgn, np;
    logic [39:0]          nmag;
    logic [36:0]          cmag;
    logic [M_W-1:0]       cmag_c;
    logic signed [M_W-1:0] chord_val;
    logic signed [39:0]   dy_w, m1_w, m2_w, other_w, e_w;
    logic signed [M_W-1:0] end_val;
    logic signed [39:0]   cc_w, ec_w;
    logic signed [22:0]   dsq_s;
    logic signed [42:0]   t1_next;
    logic signed [56:0]   t2_next;
    logic signed [69:0]   p3;
    logic signed [63:0]   yd_s, half_s, sat_lim;
    logic                 last_smp, y_neg, y_sat;

    assign step_eff = (step == '0) ? STEP_W'(1) : step;
    assign x_next   = xcur_reg + {1'b0, step_eff};
    assign u_s      = $signed({1'b0, xcur_reg - {1'b0, win_x_reg[1]}});
    assign dx_s     = $signed({2'b0, dx_reg});
    assign last_smp = (x_next > {1'b0, win_x_reg[2]})
                    || (cnt_reg == CNT_W'(MAX_SEGMENT_SAMPLES - 1));

    // chord endpoints: p0..p2 for the start tangent, p1..p3 for the end one
    assign xa = cmd.sel ? win_x_reg[1] : win_x_reg[0];
    assign ya = cmd.sel ? win_y_reg[1] : win_y_reg[0];
    assign xb = cmd.sel ? nx_reg : win_x_reg[2];
    assign yb = cmd.sel ? ny_reg : win_y_reg[2];
    assign dyc    = $signed({1'b0, yb}) - $signed({1'b0, ya});
    assign denc   = $signed({1'b0, xb}) - $signed({1'b0, xa});
    assign prod_w = dx_s * dyc;

    assign num40 = {{3{prod_reg[28]}}, prod_reg, 8'b0};
    assign nsgn  = cneg_reg ? -num40 : num40;
    assign np    = (nsgn <<< 1) + $signed({28'b0, cden_reg});
    assign nmag  = np[39] ? 40'(-np) : 40'(np);

    // floor of a negative quotient rounds the magnitude up
    assign cmag   = {1'b0, div_q} + {36'b0, dneg_reg & div_rnz};
    assign cmag_c = (cmag > 37'(TAN_HI)) ? M_W'(TAN_HI) : cmag[M_W-1:0];
    assign chord_val = czero_reg ? '0 :
                       (dneg_reg ? -$signed(cmag_c) : $signed(cmag_c));

    assign dy_w    = dy_reg;
    assign m1_w    = m1_reg;
    assign m2_w    = m2_reg;
    assign other_w = cmd.sel ? m2_w : m1_w;
    assign e_w     = (dy_w <<< 9) + (dy_w <<< 8) - other_w + 40'sd1;
    assign end_val = sat_tan(e_w >>> 1);

    assign cc_w  = (dy_w <<< 9) + (dy_w <<< 8) - (m1_w <<< 1) - m2_w;
    assign ec_w  = m1_w + m2_w - (dy_w <<< 9);
    assign dsq_s = $signed({1'b0, dsq_reg});

    assign t1_next = ec_reg * u_s + ccdx_reg;
    assign t2_next = t1_reg * u_s + m1dx2_reg;
    assign p3      = t2_reg * u_s;
    assign yd_s    = $signed({8'b0, y1den_reg, 8'b0});
    assign half_s  = $signed({24'b0, dcube_reg, 7'b0});
    assign sat_lim = $signed({8'b0, dcube_reg, 23'b0});
    assign y_neg   = t3_reg[63];
    assign y_sat   = !y_neg && (t3_reg >= sat_lim);

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = {24'b0, nmag};
        div_divisor  = {16'b0, cden_reg, 36'b0};
        div_iters    = ITER_W'(CHORD_ITERS);
        if (cmd.op == OP_CH_START)
            div_start = 1'b1;
        else if (cmd.op == OP_SMP4)
        begin
            div_start    = !y_neg && !y_sat;
            div_dividend = t3_reg;
            div_divisor  = {9'b0, dcube_reg, 22'b0};
            div_iters    = ITER_W'(SMP_ITERS);
        end
    end

    cssp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .iters    (div_iters),
        .busy     (div_busy),
        .quot     (div_q),
        .rem_nz   (div_rnz)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_reg <= '0;
        else if (cmd.op == OP_LOAD && in_first)
            held_reg <= '0;
        else if (cmd.op == OP_APPEND)
            held_reg <= held_reg + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                nx_reg <= in_x;
                ny_reg <= in_y;
            end
            OP_APPEND:
            begin
                win_x_reg[held_reg] <= nx_reg;
                win_y_reg[held_reg] <= ny_reg;
            end
            OP_SHIFT:
            begin
                win_x_reg[0] <= win_x_reg[1];
                win_y_reg[0] <= win_y_reg[1];
                win_x_reg[1] <= win_x_reg[2];
                win_y_reg[1] <= win_y_reg[2];
                win_x_reg[2] <= nx_reg;
                win_y_reg[2] <= ny_reg;
            end
            OP_PREP:
            begin
                dx_reg   <= win_x_reg[2] - win_x_reg[1];
                dy_reg   <= $signed({1'b0, win_y_reg[2]}) - $signed({1'b0, win_y_reg[1]});
                xcur_reg <= {1'b0, win_x_reg[1]};
                cnt_reg  <= '0;
            end
            OP_BOTHDUP:
            begin
                m1_reg <= M_W'(dy_w <<< 8);
                m2_reg <= M_W'(dy_w <<< 8);
            end
            OP_CH_MUL:
            begin
                prod_reg  <= prod_w;
                czero_reg <= denc == '0;
                cneg_reg  <= denc[11];
                cden_reg  <= denc[11] ? 12'(-denc) : 12'(denc);
            end
            OP_CH_START:
                dneg_reg <= np[39];
            OP_CH_FIN:
            begin
                if (cmd.sel)
                    m2_reg <= chord_val;
                else
                    m1_reg <= chord_val;
            end
            OP_END:
            begin
                if (cmd.sel)
                    m1_reg <= end_val;
                else
                    m2_reg <= end_val;
            end
            OP_COEF:
            begin
                cc_reg  <= cc_w[28:0];
                ec_reg  <= ec_w[28:0];
                dsq_reg <= dx_reg * dx_reg;
            end
            OP_COEF2:
            begin
                ccdx_reg  <= cc_reg * dx_s;
                m1dx2_reg <= m1_reg * dsq_s;
                dcube_reg <= dsq_reg * dx_reg;
            end
            OP_COEF3:
                y1den_reg <= win_y_reg[1] * dcube_reg;
            OP_SMP1:
                t1_reg <= t1_next;
            OP_SMP2:
                t2_reg <= t2_next;
            OP_SMP3:
                t3_reg <= $signed(p3[63:0]) + yd_s + half_s;
            OP_SMP4:
            begin
                out_x_reg    <= xcur_reg[X_W-1:0];
                out_last_reg <= last_smp;
                if (y_neg)
                    out_y_reg <= '0;
                else if (y_sat)
                    out_y_reg <= Y_W'(Y_MAX);
            end
            OP_DIV_FIN:
                out_y_reg <= div_q[Y_W-1:0];
            OP_ADVANCE:
            begin
                cnt_reg  <= cnt_reg + CNT_W'(1);
                xcur_reg <= x_next;
                if (last_smp)
                begin
                    win_x_reg[0] <= win_x_reg[1];
                    win_y_reg[0] <= win_y_reg[1];
                    win_x_reg[1] <= win_x_reg[2];
                    win_y_reg[1] <= win_y_reg[2];
                    win_x_reg[2] <= nx_reg;
                    win_y_reg[2] <= ny_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign status.held_full = held_reg == 2'd3;
    assign status.seg_fwd   = win_x_reg[2] > win_x_reg[1];
    assign status.dup0      = win_x_reg[0] == win_x_reg[1];
    assign status.dup3      = win_x_reg[2] == nx_reg;
    assign status.div_busy  = div_busy;
    assign status.last_smp  = last_smp;
    assign status.y_neg     = y_neg;
    assign status.y_sat     = y_sat;

    assign smp_x    = out_x_reg;
    assign smp_y    = out_y_reg;
    assign smp_last = out_last_reg;

endmodule

@@ hdl/cubic_spline_segment_sampler.sv @@
// top level of the cubic spline segment sampler: config register, sequencer, datapath
// depends on cssp_pkg, cssp_if, cssp_ctrl, cssp_datapath and the macros header
//
//   channel   dir  handshake       payload
//   points    in   valid/ready     point_x, point_y, first_of_curve
//   samples   out  valid/ready     sample_x, sample_y, last_of_segment
//   apb       in   psel/penable    sample_step at byte address 0
//
// a point that only fills the window or ends a flat segment needs just IDLE and DECIDE
// a sampled segment's setup is mostly up to two chord divides on the shared divider,
// then each sample runs SMP1 to SMP4 and, unless clamped, a 15-bit quotient divide
// one point in flight at a time; points.ready is low until its last sample is taken
// a stalled sample holds the sequencer; reset empties the window, step returns to 32
module cubic_spline_segment_sampler (
    input  logic                         clk,
    input  logic                         rst_n,
    cssp_point_if.sink                   points,
    cssp_sample_if.source                samples,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cssp_pkg::ADDR_W-1:0]  paddr,
    input  logic [cssp_pkg::DATA_W-1:0]  pwdata,
    output logic [cssp_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import cssp_pkg::*;

    `include "cubic_spline_segment_sampler_macros.svh"

    logic [STEP_W-1:0] step_reg;
    logic              cfg_wr;
    dp_cmd_t           cmd;
    dp_status_t        status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_SAMPLE_STEP);
    assign prdata = (paddr[ADDR_W-1:2] == REG_SAMPLE_STEP)
                  ? {{(DATA_W-STEP_W){1'b0}}, step_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_W'(STEP_RESET);
        else if (cfg_wr)
            step_reg <= pwdata[STEP_W-1:0];
    end

    cssp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (points.valid),
        .in_ready  (points.ready),
        .out_valid (samples.valid),
        .out_ready (samples.ready),
        .status    (status),
        .cmd       (cmd)
    );

    cssp_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .in_x     (points.point_x),
        .in_y     (points.point_y),
        .in_first (points.first_of_curve),
        .step     (step_reg),
        .smp_x    (samples.sample_x),
        .smp_y    (samples.sample_y),
        .smp_last (samples.last_of_segment)
    );

    `CSS_ASSERT_SAME(a_one_side, samples.valid, !points.ready)
    `CSS_ASSERT_NEXT(a_busy_after_request, points.valid && points.ready, !points.ready)
    `CSS_ASSERT_NEXT(a_step_written, cfg_wr, step_reg == $past(pwdata[STEP_W-1:0]))

endmodule
